### sv/rc_pulse_to_drive_commands_assert.svh
// Assertion macros for the checker file.
`ifndef RC_PULSE_TO_DRIVE_COMMANDS_ASSERT_SVH
`define RC_PULSE_TO_DRIVE_COMMANDS_ASSERT_SVH

// Clocked assertion, masked while reset is high.
`define RPDC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define RPDC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/rpdc_pkg.sv
`default_nettype none
package rpdc_pkg;

   localparam int PULSE_W  = 12;
   localparam int DRIVE_W  = 15;
   localparam int VALUE_W  = 16;
   localparam int TIME_W   = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // Map arithmetic: |pulse diff| < 2^12, |output span| < 2^16, product < 2^28
   localparam int DIFF_W = PULSE_W + 1;
   localparam int OSPAN_W = VALUE_W + 1;
   localparam int MAG_W = PULSE_W + VALUE_W;
   localparam int SUM_W = MAG_W + 2;

   localparam int NUM_CH = 6;
   localparam int CH_W = 3;
   localparam logic [CH_W-1:0] DRIVE_CHANNELS = 3'd2;
   localparam logic [CH_W-1:0] LAST_CH = 3'd5;
   localparam logic [CH_W-1:0] CH_THROTTLE = 3'd0;
   localparam logic [CH_W-1:0] CH_STEER = 3'd1;
   localparam logic [CH_W-1:0] CH_KNOB_A = 3'd2;
   localparam logic [CH_W-1:0] CH_KNOB_B = 3'd3;
   localparam logic [CH_W-1:0] CH_KNOB_C = 3'd4;
   localparam logic [CH_W-1:0] CH_KNOB_D = 3'd5;

   localparam int DIV_BITS_DEFAULT = 4;

   localparam logic [PULSE_W-1:0] CENTER_PULSE = 12'd1500;
   localparam logic [TIME_W-1:0] STOP_HOLD_MS = 32'd500;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND_LOW = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_MAX = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_KNOB_MIN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_KNOB_MAX = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_THRESHOLD = 3'd7;

   localparam logic [PULSE_W-1:0] RST_PULSE_MIN = 12'd1000;
   localparam logic [PULSE_W-1:0] RST_PULSE_MAX = 12'd2000;
   localparam logic [PULSE_W-1:0] RST_DEADBAND_LOW = 12'd1450;
   localparam logic [PULSE_W-1:0] RST_DEADBAND_HIGH = 12'd1550;
   localparam logic [DRIVE_W-1:0] RST_DRIVE_MAX = 15'd255;
   localparam logic signed [VALUE_W-1:0] RST_KNOB_MIN = 16'sd0;
   localparam logic signed [VALUE_W-1:0] RST_KNOB_MAX = 16'sd255;
   localparam logic [PULSE_W-1:0] RST_STOP_THRESHOLD = 12'd1500;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_FIX  = 5'b01000,
      ST_DONE = 5'b10000
   } rpdc_state_type;

   typedef struct packed {
      logic            load;
      logic            mul;
      logic            step;
      logic            fix;
      logic            publish;
      logic [CH_W-1:0] ch;
   } rpdc_cmd_type;

   typedef struct packed {
      logic [TIME_W-1:0]  now_ms;
      logic [PULSE_W-1:0] knob_d_pulse;
      logic [PULSE_W-1:0] knob_c_pulse;
      logic [PULSE_W-1:0] knob_b_pulse;
      logic [PULSE_W-1:0] knob_a_pulse;
      logic [PULSE_W-1:0] stop_pulse;
      logic [PULSE_W-1:0] steer_pulse;
      logic [PULSE_W-1:0] throttle_pulse;
   } rpdc_frame_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] knob_d_value;
      logic signed [VALUE_W-1:0] knob_c_value;
      logic signed [VALUE_W-1:0] knob_b_value;
      logic signed [VALUE_W-1:0] knob_a_value;
      logic                      stop_latched;
      logic signed [VALUE_W-1:0] steer_drive;
      logic signed [VALUE_W-1:0] throttle_drive;
   } rpdc_result_type;

endpackage
`default_nettype wire

### sv/rpdc_div.sv
`default_nettype none
module rpdc_div #(
   parameter int DIV_BITS = rpdc_pkg::DIV_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         load,
   input  wire logic                         step,
   input  wire logic [rpdc_pkg::MAG_W-1:0]   dividend,
   input  wire logic [rpdc_pkg::PULSE_W-1:0] divisor,
   output logic      [rpdc_pkg::MAG_W-1:0]   quotient
);

   localparam int DIV_CYCLES = (rpdc_pkg::MAG_W + DIV_BITS - 1) / DIV_BITS;
   localparam int QW = DIV_CYCLES * DIV_BITS;
   localparam int RW = rpdc_pkg::PULSE_W;

   logic [QW-1:0] work_ff, work_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] dvs_ff, dvs_in;

   // Restoring division, DIV_BITS quotient bits per cycle while step is high;
   // the quotient shifts into the low end of the dividend register.
   always_comb begin
      logic [RW-1:0] r;
      logic [RW:0]   t;
      logic [QW-1:0] w;
      r = rem_ff;
      w = work_ff;
      t = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         t = {r, w[QW-1]};
         w = {w[QW-2:0], 1'b0};
         if (t >= {1'b0, dvs_ff}) begin
            t = t - {1'b0, dvs_ff};
            w[0] = 1'b1;
         end
         r = t[RW-1:0];
      end
      work_in = work_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (load) begin
         work_in = QW'(dividend);
         rem_in = '0;
         dvs_in = divisor;
      end else if (step) begin
         work_in = w;
         rem_in = r;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = work_ff[rpdc_pkg::MAG_W-1:0];

endmodule
`default_nettype wire

### sv/rpdc_ctrl.sv
`default_nettype none
module rpdc_ctrl #(
   parameter int DIV_BITS = rpdc_pkg::DIV_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output rpdc_pkg::rpdc_cmd_type     cmd
);

   localparam int DIV_CYCLES = (rpdc_pkg::MAG_W + DIV_BITS - 1) / DIV_BITS;
   localparam int CNT_W = $clog2(DIV_CYCLES + 1);

   rpdc_pkg::rpdc_state_type state_ff, state_in;
   logic [rpdc_pkg::CH_W-1:0] ch_ff, ch_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      ch_in = ch_ff;
      cnt_in = cnt_ff;
      req_tready = 1'b0;
      cmd = '0;
      cmd.ch = ch_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         rpdc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               ch_in = '0;
               state_in = rpdc_pkg::ST_MUL;
            end
         end
         rpdc_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
            cnt_in = '0;
            state_in = rpdc_pkg::ST_DIV;
         end
         rpdc_pkg::ST_DIV: begin
            cmd.step = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_CYCLES - 1)) begin
               state_in = rpdc_pkg::ST_FIX;
            end
         end
         rpdc_pkg::ST_FIX: begin
            cmd.fix = 1'b1;
            if (ch_ff == rpdc_pkg::LAST_CH) begin
               state_in = rpdc_pkg::ST_DONE;
            end else begin
               ch_in = ch_ff + rpdc_pkg::CH_W'(1);
               state_in = rpdc_pkg::ST_MUL;
            end
         end
         rpdc_pkg::ST_DONE: begin
            // hold the finished frame until the output register frees up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.publish = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = rpdc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rpdc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpdc_pkg::ST_IDLE;
         ch_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ch_ff <= ch_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

### sv/rpdc_datapath.sv
`default_nettype none
module rpdc_datapath #(
   parameter int DIV_BITS = rpdc_pkg::DIV_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire rpdc_pkg::rpdc_cmd_type          cmd,
   input  wire rpdc_pkg::rpdc_frame_type        frame,
   input  wire logic                            csr_valid,
   input  wire logic [rpdc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rpdc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output rpdc_pkg::rpdc_result_type            result
);

   localparam int PW = rpdc_pkg::PULSE_W;
   localparam int VW = rpdc_pkg::VALUE_W;
   localparam int DW = rpdc_pkg::DIFF_W;
   localparam int OW = rpdc_pkg::OSPAN_W;
   localparam int MW = rpdc_pkg::MAG_W;
   localparam int SW = rpdc_pkg::SUM_W;

   // configuration
   logic [PW-1:0] pmin_ff, pmax_ff, dbl_ff, dbh_ff, thr_ff;
   logic [rpdc_pkg::DRIVE_W-1:0] dmax_ff;
   logic signed [VW-1:0] kmin_ff, kmax_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pmin_ff <= rpdc_pkg::RST_PULSE_MIN;
         pmax_ff <= rpdc_pkg::RST_PULSE_MAX;
         dbl_ff <= rpdc_pkg::RST_DEADBAND_LOW;
         dbh_ff <= rpdc_pkg::RST_DEADBAND_HIGH;
         dmax_ff <= rpdc_pkg::RST_DRIVE_MAX;
         kmin_ff <= rpdc_pkg::RST_KNOB_MIN;
         kmax_ff <= rpdc_pkg::RST_KNOB_MAX;
         thr_ff <= rpdc_pkg::RST_STOP_THRESHOLD;
      end else if (csr_valid) begin
         case (csr_index)
            rpdc_pkg::CSR_PULSE_MIN: pmin_ff <= csr_wdata[PW-1:0];
            rpdc_pkg::CSR_PULSE_MAX: pmax_ff <= csr_wdata[PW-1:0];
            rpdc_pkg::CSR_DEADBAND_LOW: dbl_ff <= csr_wdata[PW-1:0];
            rpdc_pkg::CSR_DEADBAND_HIGH: dbh_ff <= csr_wdata[PW-1:0];
            rpdc_pkg::CSR_DRIVE_MAX: dmax_ff <= csr_wdata[rpdc_pkg::DRIVE_W-1:0];
            rpdc_pkg::CSR_KNOB_MIN: kmin_ff <= $signed(csr_wdata);
            rpdc_pkg::CSR_KNOB_MAX: kmax_ff <= $signed(csr_wdata);
            rpdc_pkg::CSR_STOP_THRESHOLD: thr_ff <= csr_wdata[PW-1:0];
            default: begin
            end
         endcase
      end
   end

   // emergency stop latch, updated when a request is taken
   logic stop_active_ff, stop_active_in;
   logic armed_ff, armed_in;
   logic [rpdc_pkg::TIME_W-1:0] last_stop_ff, last_stop_in;
   logic [PW-1:0] stop_fill;
   logic stop_hi;
   logic [rpdc_pkg::TIME_W-1:0] elapsed;

   always_comb begin
      stop_fill = (frame.stop_pulse == '0) ? rpdc_pkg::CENTER_PULSE : frame.stop_pulse;
      stop_hi = stop_fill > thr_ff;
      elapsed = frame.now_ms - last_stop_ff;
      stop_active_in = stop_active_ff;
      armed_in = armed_ff;
      last_stop_in = last_stop_ff;
      if (cmd.load) begin
         if (elapsed > rpdc_pkg::STOP_HOLD_MS) begin
            if (!stop_hi && stop_active_ff) begin
               armed_in = 1'b1;
            end else if (stop_hi && stop_active_ff && armed_ff) begin
               stop_active_in = 1'b0;
            end else if (stop_hi && !stop_active_ff) begin
               stop_active_in = 1'b1;
            end
         end
         if (stop_hi) begin
            last_stop_in = frame.now_ms;
            armed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_active_ff <= 1'b0;
         armed_ff <= 1'b0;
         last_stop_ff <= '0;
      end else begin
         stop_active_ff <= stop_active_in;
         armed_ff <= armed_in;
         last_stop_ff <= last_stop_in;
      end
   end

   // captured pulses, one per mapped channel
   logic [PW-1:0] pulse_ff [rpdc_pkg::NUM_CH];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pulse_ff[rpdc_pkg::CH_THROTTLE] <= frame.throttle_pulse;
         pulse_ff[rpdc_pkg::CH_STEER] <= frame.steer_pulse;
         pulse_ff[rpdc_pkg::CH_KNOB_A] <= frame.knob_a_pulse;
         pulse_ff[rpdc_pkg::CH_KNOB_B] <= frame.knob_b_pulse;
         pulse_ff[rpdc_pkg::CH_KNOB_C] <= frame.knob_c_pulse;
         pulse_ff[rpdc_pkg::CH_KNOB_D] <= frame.knob_d_pulse;
      end
   end

   // map setup: pick the segment, form |diff| * |out span| and |in span|
   logic [PW-1:0] x, in_lo, in_hi;
   logic signed [OW-1:0] out_lo, out_hi, ospan;
   logic signed [DW-1:0] dx, ispan;
   logic is_drive, below, above;
   logic [PW-1:0] dx_mag, ispan_mag;
   logic [VW-1:0] ospan_mag;
   logic [MW-1:0] product;

   always_comb begin
      x = (pulse_ff[cmd.ch] == '0) ? rpdc_pkg::CENTER_PULSE : pulse_ff[cmd.ch];
      is_drive = cmd.ch < rpdc_pkg::DRIVE_CHANNELS;
      below = x < dbl_ff;
      above = x > dbh_ff;
      in_lo = pmin_ff;
      in_hi = pmax_ff;
      out_lo = OW'(kmin_ff);
      out_hi = OW'(kmax_ff);
      if (is_drive && below) begin
         in_hi = dbl_ff;
         out_lo = -$signed({2'b00, dmax_ff});
         out_hi = -OW'(1);
      end else if (is_drive) begin
         in_lo = dbh_ff;
         out_lo = OW'(1);
         out_hi = $signed({2'b00, dmax_ff});
      end
      dx = $signed({1'b0, x}) - $signed({1'b0, in_lo});
      ispan = $signed({1'b0, in_hi}) - $signed({1'b0, in_lo});
      ospan = out_hi - out_lo;
      dx_mag = PW'(dx[DW-1] ? -dx : dx);
      ispan_mag = PW'(ispan[DW-1] ? -ispan : ispan);
      ospan_mag = VW'(ospan[OW-1] ? -ospan : ospan);
      product = MW'(dx_mag) * MW'(ospan_mag);
   end

   logic neg_ff, zspan_ff, dead_ff;
   logic signed [OW-1:0] lo_ff, hi_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         neg_ff <= dx[DW-1] ^ ospan[OW-1] ^ ispan[DW-1];
         zspan_ff <= ispan == '0;
         dead_ff <= is_drive && !below && !above;
         lo_ff <= out_lo;
         hi_ff <= out_hi;
      end
   end

   logic [MW-1:0] quotient;

   rpdc_div #(
      .DIV_BITS(DIV_BITS)
   ) u_div (
      .clock(clock),
      .load(cmd.mul),
      .step(cmd.step),
      .dividend(product),
      .divisor(ispan_mag),
      .quotient(quotient)
   );

   // apply sign, add the offset, clamp, zero inside the drive deadband
   logic signed [SW-1:0] qs, lo_ext, hi_ext, sum, clamped;
   logic signed [VW-1:0] ch_value;
   logic signed [VW-1:0] res_ff [rpdc_pkg::NUM_CH];

   always_comb begin
      lo_ext = SW'(lo_ff);
      hi_ext = SW'(hi_ff);
      qs = neg_ff ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});
      sum = zspan_ff ? lo_ext : qs + lo_ext;
      if (sum < lo_ext) begin
         clamped = lo_ext;
      end else if (sum > hi_ext) begin
         clamped = hi_ext;
      end else begin
         clamped = sum;
      end
      ch_value = dead_ff ? '0 : clamped[VW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.fix) begin
         res_ff[cmd.ch] <= ch_value;
      end
   end

   rpdc_pkg::rpdc_result_type out_ff;

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_ff.throttle_drive <= res_ff[rpdc_pkg::CH_THROTTLE];
         out_ff.steer_drive <= res_ff[rpdc_pkg::CH_STEER];
         out_ff.stop_latched <= stop_active_ff;
         out_ff.knob_a_value <= res_ff[rpdc_pkg::CH_KNOB_A];
         out_ff.knob_b_value <= res_ff[rpdc_pkg::CH_KNOB_B];
         out_ff.knob_c_value <= res_ff[rpdc_pkg::CH_KNOB_C];
         out_ff.knob_d_value <= res_ff[rpdc_pkg::CH_KNOB_D];
      end
   end

   assign result = out_ff;

endmodule
`default_nettype wire

### sv/rc_pulse_to_drive_commands.sv
// Receiver frame to drive commands.
// req_* takes one frame: seven 12-bit pulse widths and a 32-bit millisecond
// time stamp. rsp_* returns one result per frame: signed throttle and steering
// drive, the emergency-stop latch, and four mapped knob values.
// csr_* writes one of eight mapping registers by index; csr_ready is always
// high. Write registers only while no frame is in flight.
// Each frame runs six linear maps through one shared restoring divider that
// retires DIV_BITS quotient bits per cycle over a 28-bit dividend. Each map
// steps through the multiply, divide and fix-up states in turn; rsp_tvalid
// rises once all six maps are done and the result is published, and a new
// request is taken only in the idle state, after the previous frame's result
// has been published.
// The result sits in an output register: the next frame is taken and computed
// while it waits; if rsp_tready is still low when that next frame is done,
// the block holds it and takes no further request until the register frees.
// Reset (synchronous, active high) restores register defaults, clears the
// stop latch, its time stamp and release arming, and drops rsp_tvalid.
`default_nettype none
module rc_pulse_to_drive_commands #(
   // quotient bits per divider cycle, 1 to 8
   parameter int DIV_BITS = rpdc_pkg::DIV_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // throttle[11:0] steer[23:12] stop[35:24] knob_a[47:36] knob_b[59:48]
   // knob_c[71:60] knob_d[83:72] now_ms[115:84], zero fill to 120
   input  wire logic [119:0]                    req_tdata,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // throttle_drive[15:0] steer_drive[31:16] stop_latched[32]
   // knob_a[48:33] knob_b[64:49] knob_c[80:65] knob_d[96:81], zero fill to 104
   output logic [103:0]                         rsp_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [rpdc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rpdc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   rpdc_pkg::rpdc_cmd_type cmd;
   rpdc_pkg::rpdc_frame_type frame;
   rpdc_pkg::rpdc_result_type result;

   assign frame.throttle_pulse = req_tdata[11:0];
   assign frame.steer_pulse = req_tdata[23:12];
   assign frame.stop_pulse = req_tdata[35:24];
   assign frame.knob_a_pulse = req_tdata[47:36];
   assign frame.knob_b_pulse = req_tdata[59:48];
   assign frame.knob_c_pulse = req_tdata[71:60];
   assign frame.knob_d_pulse = req_tdata[83:72];
   assign frame.now_ms = req_tdata[115:84];

   assign csr_ready = 1'b1;

   rpdc_ctrl #(
      .DIV_BITS(DIV_BITS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd(cmd)
   );

   rpdc_datapath #(
      .DIV_BITS(DIV_BITS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .frame(frame),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .result(result)
   );

   assign rsp_tdata = {7'b0, result.knob_d_value, result.knob_c_value,
                       result.knob_b_value, result.knob_a_value, result.stop_latched,
                       result.steer_drive, result.throttle_drive};

endmodule
`default_nettype wire

### sv/rpdc_checker.sv
`default_nettype none
`include "rc_pulse_to_drive_commands_assert.svh"
module rpdc_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [103:0] rsp_tdata,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready
);

   logic req_take;

   assign req_take = req_tvalid && req_tready;

   `RPDC_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_tvalid && req_tready), "reset must drop rsp_tvalid and return to ready")
   `RPDC_ASSERT(a_busy_after_take, clock, reset, req_take |=> !req_tready, "request taken while previous frame still in work")
   `RPDC_ASSERT(a_publish_frees_input, clock, reset, $rose(rsp_tvalid) |-> req_tready, "input not ready after a result was published")
   `RPDC_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "stalled result changed or dropped")

endmodule

bind rc_pulse_to_drive_commands rpdc_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready)
);
`default_nettype wire
